/* hdl/assert_macros.svh */
// Assertion macros shared by the triangle weight block.
// Needs nothing else; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TBW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed.");

// Next-cycle implication, disabled while reset is high.
`define TBW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed.");

`endif

/* hdl/tbw_pkg.sv */
// Package for the triangle weight block: default parameters, case codes,
// result type and the operand tables of the vector pipeline. Depends on nothing.
package tbw_pkg;

   localparam int COORD_WIDTH_DEF      = 24;
   localparam int WEIGHT_FRAC_BITS_DEF = 16;
   localparam int WEIGHT_WIDTH         = 24;
   localparam int THR_WIDTH            = 24;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 24'd167772;
   localparam int DET_SCALE_BITS       = 24;

   localparam int NUM_POINTS = 4;
   localparam int AXES       = 3;
   localparam int NUM_DIFFS  = 6;
   localparam int NUM_PAIRS  = 8;
   localparam int NUM_MULS   = 6;

   localparam int PT_A = 0;
   localparam int PT_B = 1;
   localparam int PT_C = 2;
   localparam int PT_Q = 3;

   localparam int DIF_A  = 0;
   localparam int DIF_B  = 1;
   localparam int DIF_C  = 2;
   localparam int DIF_E0 = 3;
   localparam int DIF_E1 = 4;
   localparam int DIF_E2 = 5;

   localparam int DIF_PLUS  [NUM_DIFFS] = '{PT_A, PT_B, PT_C, PT_B, PT_C, PT_Q};
   localparam int DIF_MINUS [NUM_DIFFS] = '{PT_Q, PT_Q, PT_Q, PT_A, PT_A, PT_A};

   localparam int DOT_AA = 0;
   localparam int DOT_BB = 1;
   localparam int DOT_CC = 2;
   localparam int DOT_00 = 3;
   localparam int DOT_01 = 4;
   localparam int DOT_11 = 5;
   localparam int DOT_20 = 6;
   localparam int DOT_21 = 7;

   localparam int PAIR_X [NUM_PAIRS] =
      '{DIF_A, DIF_B, DIF_C, DIF_E0, DIF_E0, DIF_E1, DIF_E2, DIF_E2};
   localparam int PAIR_Y [NUM_PAIRS] =
      '{DIF_A, DIF_B, DIF_C, DIF_E0, DIF_E1, DIF_E1, DIF_E0, DIF_E1};

   // Products for the determinant and the two numerators, in subtraction pairs.
   localparam int MUL_A [NUM_MULS] = '{DOT_00, DOT_01, DOT_11, DOT_01, DOT_00, DOT_01};
   localparam int MUL_B [NUM_MULS] = '{DOT_11, DOT_01, DOT_20, DOT_21, DOT_21, DOT_20};

   typedef enum logic [2:0] {
      CASE_BLEND  = 3'd0,
      CASE_SNAP_A = 3'd1,
      CASE_SNAP_B = 3'd2,
      CASE_SNAP_C = 3'd3,
      CASE_DEGEN  = 3'd4
   } case_code_type;

   typedef struct packed {
      logic signed [WEIGHT_WIDTH-1:0] u;
      logic signed [WEIGHT_WIDTH-1:0] v;
      logic signed [WEIGHT_WIDTH-1:0] w;
      case_code_type                  code;
   } result_type;

endpackage

/* hdl/tbw_mul.sv */
// Two-stage signed multiplier built from four half-width partial products.
// Self-contained; used by the triangle weight top level.
module tbw_mul #(
   parameter int OP_WIDTH = 52
) (
   input  logic                         clock,
   input  logic                         enable,
   input  logic signed [OP_WIDTH-1:0]   op_a,
   input  logic signed [OP_WIDTH-1:0]   op_b,
   output logic signed [2*OP_WIDTH-1:0] product
);
   localparam int LO_W   = OP_WIDTH / 2;
   localparam int HI_W   = OP_WIDTH - LO_W;
   localparam int PROD_W = 2 * OP_WIDTH;

   logic signed [HI_W-1:0]        a_hi, b_hi;
   logic signed [LO_W:0]          a_lo, b_lo;
   logic signed [2*HI_W-1:0]      hh_in, hh_ff;
   logic signed [OP_WIDTH:0]      hl_in, hl_ff, lh_in, lh_ff;
   logic        [2*LO_W-1:0]      ll_in, ll_ff;
   logic signed [PROD_W-1:0]      product_in, product_ff;

   assign a_hi  = $signed(op_a[OP_WIDTH-1:LO_W]);
   assign b_hi  = $signed(op_b[OP_WIDTH-1:LO_W]);
   assign a_lo  = $signed({1'b0, op_a[LO_W-1:0]});
   assign b_lo  = $signed({1'b0, op_b[LO_W-1:0]});
   assign hh_in = a_hi * b_hi;
   assign hl_in = a_hi * b_lo;
   assign lh_in = a_lo * b_hi;
   assign ll_in = op_a[LO_W-1:0] * op_b[LO_W-1:0];

   assign product_in = (PROD_W'(hh_ff) <<< (2 * LO_W))
                     + (PROD_W'(hl_ff) <<< LO_W)
                     + (PROD_W'(lh_ff) <<< LO_W)
                     + $signed(PROD_W'(ll_ff));

   always_ff @(posedge clock) begin
      if (enable) begin
         hh_ff      <= hh_in;
         hl_ff      <= hl_in;
         lh_ff      <= lh_in;
         ll_ff      <= ll_in;
         product_ff <= product_in;
      end
   end

   assign product = product_ff;
endmodule

/* hdl/tbw_div.sv */
// Pipelined restoring divider: one quotient bit per stage, numerator scaled by
// the fraction bits. Self-contained; used by the triangle weight top level.
module tbw_div #(
   parameter int NUM_WIDTH = 105,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [NUM_WIDTH-1:0]         numer,
   input  logic signed [NUM_WIDTH-1:0]         denom,
   output logic        [NUM_WIDTH+FRAC_BITS-1:0] quotient,
   output logic                                negative
);
   localparam int QW = NUM_WIDTH + FRAC_BITS;
   localparam int RW = NUM_WIDTH - 1;

   logic [RW-1:0] rem_ff  [QW+1];
   logic [QW-1:0] rq_ff   [QW+1];
   logic [RW-1:0] dvs_ff  [QW+1];
   logic          sign_ff [QW+1];
   logic [NUM_WIDTH-1:0] mag;

   assign mag = numer[NUM_WIDTH-1] ? $unsigned(-numer) : $unsigned(numer);

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= '0;
         rq_ff[0]   <= {mag, {FRAC_BITS{1'b0}}};
         dvs_ff[0]  <= denom[RW-1:0];
         sign_ff[0] <= numer[NUM_WIDTH-1];
      end
   end

   for (genvar s = 1; s <= QW; s++) begin : g_stage
      logic [NUM_WIDTH-1:0] trial, diff;
      logic                 ge;
      assign trial = {rem_ff[s-1], rq_ff[s-1][QW-1]};
      assign diff  = trial - {1'b0, dvs_ff[s-1]};
      assign ge    = trial >= {1'b0, dvs_ff[s-1]};
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
            rq_ff[s]   <= {rq_ff[s-1][QW-2:0], ge};
            dvs_ff[s]  <= dvs_ff[s-1];
            sign_ff[s] <= sign_ff[s-1];
         end
      end
   end

   assign quotient = rq_ff[QW];
   assign negative = sign_ff[QW];
endmodule

/* hdl/tbw_delay.sv */
// Stallable delay line that carries valid bits and case codes beside the divider.
// Self-contained; used by the triangle weight top level.
module tbw_delay #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) stage_ff[i] <= '0;
      end else if (enable) begin
         stage_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) stage_ff[i] <= stage_ff[i-1];
      end
   end

   assign dout = stage_ff[DEPTH-1];
endmodule

/* hdl/triangle_barycentric_weights_top.sv */
// Triangle barycentric weights, top level: vector pipeline, split multipliers,
// two pipelined dividers and output skid buffer. Uses tbw_pkg and the tbw_* modules.
//
// One beat is accepted every cycle while req_stall is low, and each beat gives exactly
// one result beat, in order. The divider, one quotient bit per stage over the scaled
// numerator, makes up most of the pipeline from acceptance to the result register.
// A two-entry output buffer keeps input acceptance going for one beat after the
// sink stalls; req_stall is a registered signal. The threshold register may be
// rewritten only while no beat is in flight.
`include "assert_macros.svh"

module triangle_barycentric_weights_top #(
   parameter int COORD_WIDTH      = tbw_pkg::COORD_WIDTH_DEF,
   parameter int WEIGHT_FRAC_BITS = tbw_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [COORD_WIDTH-1:0]           req_corner_a_x,
   input  logic signed [COORD_WIDTH-1:0]           req_corner_a_y,
   input  logic signed [COORD_WIDTH-1:0]           req_corner_a_z,
   input  logic signed [COORD_WIDTH-1:0]           req_corner_b_x,
   input  logic signed [COORD_WIDTH-1:0]           req_corner_b_y,
   input  logic signed [COORD_WIDTH-1:0]           req_corner_b_z,
   input  logic signed [COORD_WIDTH-1:0]           req_corner_c_x,
   input  logic signed [COORD_WIDTH-1:0]           req_corner_c_y,
   input  logic signed [COORD_WIDTH-1:0]           req_corner_c_z,
   input  logic signed [COORD_WIDTH-1:0]           req_query_x,
   input  logic signed [COORD_WIDTH-1:0]           req_query_y,
   input  logic signed [COORD_WIDTH-1:0]           req_query_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [tbw_pkg::WEIGHT_WIDTH-1:0] rsp_weight_u,
   output logic signed [tbw_pkg::WEIGHT_WIDTH-1:0] rsp_weight_v,
   output logic signed [tbw_pkg::WEIGHT_WIDTH-1:0] rsp_weight_w,
   output logic        [2:0]                       rsp_case_code,
   input  logic                                    csr_wr_en,
   input  logic        [tbw_pkg::THR_WIDTH-1:0]    csr_wr_data
);
   import tbw_pkg::*;

   localparam int DW    = COORD_WIDTH + 1;
   localparam int SQW   = 2 * DW;
   localparam int DOTW  = SQW + 2;
   localparam int PRODW = 2 * DOTW;
   localparam int PW    = PRODW + 1;
   localparam int NW    = PW + WEIGHT_FRAC_BITS;
   localparam int QW    = NW + 1;
   localparam int UW    = NW + 3;
   localparam int WW    = WEIGHT_WIDTH;
   localparam int LANE_W = 4;

   localparam logic signed [WW-1:0] WMAX = {1'b0, {(WW-1){1'b1}}};
   localparam logic signed [WW-1:0] WMIN = {1'b1, {(WW-1){1'b0}}};
   localparam logic signed [UW-1:0] SAT_MAX_WIDE = UW'(WMAX);
   localparam logic signed [UW-1:0] SAT_MIN_WIDE = UW'(WMIN);
   localparam logic signed [UW-1:0] ONE_WIDE =
      {{(UW-WEIGHT_FRAC_BITS-1){1'b0}}, 1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
   localparam logic signed [WW-1:0] ONE_SAT =
      (WEIGHT_FRAC_BITS >= WW - 1) ? WMAX : WW'(ONE_WIDE);

   function automatic logic signed [WW-1:0] sat_weight(input logic signed [UW-1:0] x);
      if (x > SAT_MAX_WIDE) return WMAX;
      else if (x < SAT_MIN_WIDE) return WMIN;
      else return x[WW-1:0];
   endfunction

   logic en;
   logic [THR_WIDTH-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // Stage 1: coordinate differences.
   logic signed [COORD_WIDTH-1:0] pt [NUM_POINTS][AXES];
   logic signed [DW-1:0] dif_in [NUM_DIFFS][AXES];
   logic signed [DW-1:0] dif_ff [NUM_DIFFS][AXES];
   logic v1_ff;

   assign pt[PT_A][0] = req_corner_a_x;
   assign pt[PT_A][1] = req_corner_a_y;
   assign pt[PT_A][2] = req_corner_a_z;
   assign pt[PT_B][0] = req_corner_b_x;
   assign pt[PT_B][1] = req_corner_b_y;
   assign pt[PT_B][2] = req_corner_b_z;
   assign pt[PT_C][0] = req_corner_c_x;
   assign pt[PT_C][1] = req_corner_c_y;
   assign pt[PT_C][2] = req_corner_c_z;
   assign pt[PT_Q][0] = req_query_x;
   assign pt[PT_Q][1] = req_query_y;
   assign pt[PT_Q][2] = req_query_z;

   for (genvar d = 0; d < NUM_DIFFS; d++) begin : g_dif
      for (genvar i = 0; i < AXES; i++) begin : g_axis
         assign dif_in[d][i] = DW'(pt[DIF_PLUS[d]][i]) - DW'(pt[DIF_MINUS[d]][i]);
      end
   end

   // Stage 2: per-axis products; stage 3: dot products.
   logic signed [SQW-1:0]  prod_in [NUM_PAIRS][AXES];
   logic signed [SQW-1:0]  prod_ff [NUM_PAIRS][AXES];
   logic signed [DOTW-1:0] dot_in  [NUM_PAIRS];
   logic signed [DOTW-1:0] dot_ff  [NUM_PAIRS];
   logic v2_ff, v3_ff;

   for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_pair
      for (genvar i = 0; i < AXES; i++) begin : g_axis
         assign prod_in[k][i] = dif_ff[PAIR_X[k]][i] * dif_ff[PAIR_Y[k]][i];
      end
      assign dot_in[k] = DOTW'(prod_ff[k][0]) + DOTW'(prod_ff[k][1])
                       + DOTW'(prod_ff[k][2]);
   end

   // Stage 4: corner snapping; stages 4 and 5: wide products.
   logic signed [DOTW-1:0]  thr_dot;
   case_code_type           code4_in, code4_ff, code5_ff, code6_ff, code7_in, code7_ff;
   logic                    v4_ff, v5_ff, v6_ff, v7_ff;
   logic signed [PRODW-1:0] mul_prod [NUM_MULS];

   assign thr_dot = $signed(DOTW'(thr_ff));

   always_comb begin
      if (dot_ff[DOT_AA] < thr_dot) code4_in = CASE_SNAP_A;
      else if (dot_ff[DOT_BB] < thr_dot) code4_in = CASE_SNAP_B;
      else if (dot_ff[DOT_CC] < thr_dot) code4_in = CASE_SNAP_C;
      else code4_in = CASE_BLEND;
   end

   for (genvar m = 0; m < NUM_MULS; m++) begin : g_mul
      tbw_mul #(.OP_WIDTH(DOTW)) u_mul (
         .clock   (clock),
         .enable  (en),
         .op_a    (dot_ff[MUL_A[m]]),
         .op_b    (dot_ff[MUL_B[m]]),
         .product (mul_prod[m])
      );
   end

   // Stage 6: determinant and numerators; stage 7: degeneracy test.
   logic signed [PW-1:0] den_ff, nv_ff, nw_ff, thr_det;
   logic                 degen;

   assign thr_det = $signed(PW'({thr_ff, {DET_SCALE_BITS{1'b0}}}));
   assign degen   = (den_ff < thr_det) || den_ff[PW-1] || (den_ff == '0);
   assign code7_in = (code6_ff == CASE_BLEND && degen) ? CASE_DEGEN : code6_ff;

   // Dividers and the side lane that runs beside them.
   logic [NW-1:0]     quo_v, quo_w;
   logic              neg_v, neg_w;
   logic [LANE_W-1:0] lane_out;

   tbw_div #(.NUM_WIDTH(PW), .FRAC_BITS(WEIGHT_FRAC_BITS)) u_div_v (
      .clock    (clock),
      .enable   (en),
      .numer    (nv_ff),
      .denom    (den_ff),
      .quotient (quo_v),
      .negative (neg_v)
   );

   tbw_div #(.NUM_WIDTH(PW), .FRAC_BITS(WEIGHT_FRAC_BITS)) u_div_w (
      .clock    (clock),
      .enable   (en),
      .numer    (nw_ff),
      .denom    (den_ff),
      .quotient (quo_w),
      .negative (neg_w)
   );

   tbw_delay #(.WIDTH(LANE_W), .DEPTH(NW)) u_lane (
      .clock  (clock),
      .reset  (reset),
      .enable (en),
      .din    ({v7_ff, code7_ff}),
      .dout   (lane_out)
   );

   // Completion stages: signed quotients, exact u, saturation and selection.
   logic signed [QW-1:0] qv_in, qw_in, qv_ff, qw_ff;
   logic signed [UW-1:0] u_ff;
   logic signed [WW-1:0] vsat_ff, wsat_ff, usat;
   case_code_type        code_c1_ff, code_c2_ff;
   logic                 vc1_ff, vc2_ff, res_valid_ff;
   result_type           res_in, res_ff, skid_ff, rsp_data_ff;
   logic                 skid_full_ff, rsp_valid_ff;

   assign qv_in = neg_v ? -$signed({1'b0, quo_v}) : $signed({1'b0, quo_v});
   assign qw_in = neg_w ? -$signed({1'b0, quo_w}) : $signed({1'b0, quo_w});
   assign usat  = sat_weight(u_ff);

   always_comb begin
      res_in.code = code_c2_ff;
      case (code_c2_ff)
         CASE_BLEND: begin
            res_in.u = usat;
            res_in.v = vsat_ff;
            res_in.w = wsat_ff;
         end
         CASE_SNAP_A, CASE_DEGEN: begin
            res_in.u = ONE_SAT;
            res_in.v = '0;
            res_in.w = '0;
         end
         CASE_SNAP_B: begin
            res_in.u = '0;
            res_in.v = ONE_SAT;
            res_in.w = '0;
         end
         CASE_SNAP_C: begin
            res_in.u = '0;
            res_in.v = '0;
            res_in.w = ONE_SAT;
         end
         default: begin
            res_in.u = '0;
            res_in.v = '0;
            res_in.w = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         vc1_ff       <= 1'b0;
         vc2_ff       <= 1'b0;
         res_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         vc1_ff       <= lane_out[LANE_W-1];
         vc2_ff       <= vc1_ff;
         res_valid_ff <= vc2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dif_ff     <= dif_in;
         prod_ff    <= prod_in;
         dot_ff     <= dot_in;
         code4_ff   <= code4_in;
         code5_ff   <= code4_ff;
         code6_ff   <= code5_ff;
         den_ff     <= PW'(mul_prod[0]) - PW'(mul_prod[1]);
         nv_ff      <= PW'(mul_prod[2]) - PW'(mul_prod[3]);
         nw_ff      <= PW'(mul_prod[4]) - PW'(mul_prod[5]);
         code7_ff   <= code7_in;
         qv_ff      <= qv_in;
         qw_ff      <= qw_in;
         code_c1_ff <= case_code_type'(lane_out[LANE_W-2:0]);
         u_ff       <= ONE_WIDE - UW'(qv_ff) - UW'(qw_ff);
         vsat_ff    <= sat_weight(UW'(qv_ff));
         wsat_ff    <= sat_weight(UW'(qw_ff));
         code_c2_ff <= code_c1_ff;
         res_ff     <= res_in;
      end
   end

   // Output register with a one-beat skid entry behind it.
   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= skid_full_ff || res_valid_ff;
         skid_full_ff <= 1'b0;
      end else if (res_valid_ff && en) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_data_ff <= skid_full_ff ? skid_ff : res_ff;
      end else if (!skid_full_ff) begin
         skid_ff <= res_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_weight_u  = rsp_data_ff.u;
   assign rsp_weight_v  = rsp_data_ff.v;
   assign rsp_weight_w  = rsp_data_ff.w;
   assign rsp_case_code = rsp_data_ff.code;

   logic out_unit_u, out_snap_a, out_degen;

   assign out_unit_u = rsp_data_ff.u == ONE_SAT && rsp_data_ff.v == '0
                       && rsp_data_ff.w == '0;
   assign out_snap_a = rsp_valid_ff && rsp_data_ff.code == CASE_SNAP_A;
   assign out_degen  = rsp_valid_ff && rsp_data_ff.code == CASE_DEGEN;

   `TBW_ASSERT_IMP(a_skid_behind_output, clock, reset, skid_full_ff, rsp_valid_ff)
   `TBW_ASSERT_NEXT(a_skid_held_on_stall, clock, reset, skid_full_ff && rsp_stall, skid_full_ff)
   `TBW_ASSERT_IMP(a_snap_a_weights, clock, reset, out_snap_a, out_unit_u)
   `TBW_ASSERT_IMP(a_degen_weights, clock, reset, out_degen, out_unit_u)
endmodule
